>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// Assumes the asserting module has clk_i and active-low rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> hw/rtl/twl_pkg.sv
// Types, constants and the symbol map for the trie word lookup.
// No dependencies.
`default_nettype none

package twl_pkg;

  localparam int unsigned NODE_COUNT    = 65536;
  localparam int unsigned ALPHABET_SIZE = 26 + 10 + 1;
  localparam int unsigned NODE_W        = $clog2(NODE_COUNT);
  localparam int unsigned NODE_CNT_W    = NODE_W + 1;
  localparam int unsigned SLOT_COUNT    = NODE_COUNT * ALPHABET_SIZE;
  localparam int unsigned SLOT_W        = $clog2(SLOT_COUNT);
  localparam int unsigned SYM_W         = $clog2(ALPHABET_SIZE);
  localparam int unsigned CHAR_W        = 8;
  localparam int unsigned PAYLOAD_W     = 17;

  localparam logic [CHAR_W-1:0] CH_LC_A = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CH_LC_Z = 8'h7A;  // 'z'
  localparam logic [CHAR_W-1:0] CH_D0   = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CH_D9   = 8'h39;  // '9'
  localparam logic [CHAR_W-1:0] CH_US   = 8'h5F;  // '_'

  localparam logic [SYM_W-1:0] SYM_DIGIT0 = SYM_W'(26);
  localparam logic [SYM_W-1:0] SYM_US     = SYM_W'(36);

  localparam logic OP_QUERY  = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } twl_status_e;

  typedef struct packed {
    logic                 opcode;
    logic [CHAR_W-1:0]    char_code;
    logic                 last_char;
    logic [PAYLOAD_W-1:0] payload_index;
  } twl_in_t;

  typedef struct packed {
    twl_status_e          status;
    logic [PAYLOAD_W-1:0] result_index;
  } twl_out_t;

  // Per-node record: payload, its valid mark, and the link slot that
  // created the node (used to tell live links from stale memory content).
  typedef struct packed {
    logic                 valid;
    logic [PAYLOAD_W-1:0] payload;
    logic [SLOT_W-1:0]    parent;
  } twl_node_t;

  function automatic logic [SYM_W-1:0] symbol_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] diff;
    begin
      diff = '0;
      if (c >= CH_LC_A && c <= CH_LC_Z) begin
        diff = c - CH_LC_A;
        symbol_of = diff[SYM_W-1:0];
      end else if (c >= CH_D0 && c <= CH_D9) begin
        diff = c - CH_D0;
        symbol_of = SYM_DIGIT0 + diff[SYM_W-1:0];
      end else if (c == CH_US) begin
        symbol_of = SYM_US;
      end else begin
        symbol_of = '0;
      end
    end
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/trie_word_lookup.sv
// Trie word lookup: character trie with insert and query, one character per item.
// Depends on twl_pkg and assert_macros.svh.
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+----------------------------
//  in      | in  | in_valid_i / in_ready_o   | twl_in_t  (one character)
//  out     | out | out_valid_o / out_ready_i | twl_out_t (one per word)
//
// Each character passes through accept (child link read issued), link data
// back (node record read issued at the child), then the decision cycle that
// writes back. The two dependent memory reads set this sequence.
// The result of a word's last character is registered at its
// decision. Reset takes effect at once; no clearing pass is needed: a link
// counts only if its child is below the node counter and that child's
// record names this very slot as its parent. A last character waits in
// its decision cycle while the previous result has not been taken.
`default_nettype none
`include "assert_macros.svh"

module trie_word_lookup (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire twl_pkg::twl_in_t  in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output twl_pkg::twl_out_t      out_item_o
);
  import twl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,  // waiting for a character
    S_LINK = 3'b010,  // child link data arriving
    S_NODE = 3'b100   // node record arriving, decide and write back
  } twl_state_e;

  // Storage: child links per (node, symbol) slot, and one record per node.
  logic [NODE_W-1:0] link_mem [SLOT_COUNT];
  twl_node_t         node_mem [NODE_COUNT];

  twl_state_e            state_q, state_d;
  twl_in_t               item_q;
  logic [SLOT_W-1:0]     slot_q, slot_d;
  logic [NODE_W-1:0]     cur_q, cur_d;
  logic [NODE_CNT_W-1:0] nf_q, nf_d;
  logic                  fail_q, fail_d;
  logic                  out_valid_q, out_valid_d;
  twl_out_t              out_item_q, out_item_d;

  logic [NODE_W-1:0] link_rd_q;
  twl_node_t         node_rd_q;

  logic              in_acc;
  logic              go;
  logic              dec;
  logic              link_ok;
  logic              link_we;
  logic              node_we;
  twl_node_t         node_wdata;
  logic [NODE_W-1:0] node_sel;
  twl_node_t         rec_sel;
  logic              fail_n;
  logic              out_load;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Slot address of the child link for the arriving character.
  assign slot_d = SLOT_W'(cur_q) * SLOT_W'(ALPHABET_SIZE)
                + SLOT_W'(symbol_of(in_item_i.char_code));

  // A last character needs a free result register before it commits.
  assign go  = !item_q.last_char || !out_valid_q || out_ready_i;
  assign dec = (state_q == S_NODE) && go;

  // Live link: nonzero, already allocated, and created from this slot.
  assign link_ok = (link_rd_q != '0)
                && ({1'b0, link_rd_q} < nf_q)
                && (node_rd_q.parent == slot_q);

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    nf_d        = nf_q;
    fail_d      = fail_q;
    link_we     = 1'b0;
    node_we     = 1'b0;
    node_sel    = cur_q;
    rec_sel     = node_rd_q;
    fail_n      = fail_q;
    out_load    = 1'b0;
    out_item_d  = out_item_q;
    node_wdata  = '{valid: 1'b0, payload: item_q.payload_index, parent: slot_q};

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_LINK;
        end
      end
      S_LINK: begin
        state_d = S_NODE;
      end
      S_NODE: begin
        if (go) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (dec) begin
      if (!fail_q) begin
        if (link_ok) begin
          node_sel = link_rd_q;
        end else if (item_q.opcode == OP_INSERT && nf_q < NODE_CNT_W'(NODE_COUNT)) begin
          // allocate the next node and link it from this slot
          link_we  = 1'b1;
          node_we  = 1'b1;
          node_sel = nf_q[NODE_W-1:0];
          nf_d     = nf_q + NODE_CNT_W'(1);
          rec_sel  = '{valid: 1'b0, payload: item_q.payload_index, parent: slot_q};
        end else begin
          fail_n = 1'b1;
        end
      end

      if (item_q.last_char) begin
        out_load = 1'b1;
        if (fail_n) begin
          out_item_d.status       = (item_q.opcode == OP_INSERT) ? ST_FULL : ST_MISS;
          out_item_d.result_index = '0;
        end else if (item_q.opcode == OP_INSERT) begin
          node_we    = 1'b1;
          node_wdata = '{valid: 1'b1, payload: item_q.payload_index,
                         parent: rec_sel.parent};
          out_item_d.status       = ST_OK;
          out_item_d.result_index = item_q.payload_index;
        end else if (rec_sel.valid) begin
          out_item_d.status       = ST_OK;
          out_item_d.result_index = rec_sel.payload;
        end else begin
          out_item_d.status       = ST_MISS;
          out_item_d.result_index = '0;
        end
        cur_d  = '0;
        fail_d = 1'b0;
      end else begin
        cur_d  = node_sel;
        fail_d = fail_n;
      end
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      nf_q        <= NODE_CNT_W'(1);
      fail_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      nf_q        <= nf_d;
      fail_q      <= fail_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_item_i;
      slot_q <= slot_d;
    end
    if (out_load) begin
      out_item_q <= out_item_d;
    end
  end

  // Child link memory: read at accept, written on allocation.
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[slot_q] <= nf_q[NODE_W-1:0];
    end
    if (in_acc) begin
      link_rd_q <= link_mem[slot_d];
    end
  end

  // Node record memory: read at the child, written in the decision cycle.
  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_sel] <= node_wdata;
    end
    if (state_q == S_LINK) begin
      node_rd_q <= node_mem[link_rd_q];
    end
  end

  `ASSERT_CLK(a_nf_bound, nf_q <= NODE_CNT_W'(NODE_COUNT), "node counter past pool size")
  `ASSERT_CLK(a_cur_alloc, {1'b0, cur_q} < nf_q, "current node not allocated")
  `ASSERT_CLK(a_alloc_step, link_we |=> (nf_q == $past(nf_q) + NODE_CNT_W'(1)), "bad allocation step")
  `ASSERT_CLK(a_alloc_rec, link_we |-> (node_we && node_sel == nf_q[NODE_W-1:0]), "allocation without node record")
  `ASSERT_CLK(a_out_src, $rose(out_valid_q) |-> $past(state_q == S_NODE), "result outside decision")

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for trie_word_lookup: inserts and queries words one
// character per item and checks every per-word answer against a local trie model.
// Depends on twl_pkg and the trie_word_lookup RTL.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import twl_pkg::*;

  // Longest word in the random dictionary.
  localparam int unsigned WORD_MAX    = 8;
  localparam int unsigned DICT_MAX    = 256;
  localparam int unsigned RAND_ITEMS  = 1600;
  // No correct run goes this long without a handshake on either side: it covers the
  // longest input gap, a character's passage through the block and the longest output stall.
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef enum int {
    WORD_QUERY,
    WORD_INSERT,
    WORD_MIXED
  } word_kind_e;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  twl_in_t  in_item;
  logic     out_valid;
  logic     out_ready;
  twl_out_t out_item;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  trie_word_lookup u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  // ---------------------------------------------------------------------------
  // Trie model. Links live in a sparse map keyed by node * ALPHABET_SIZE + symbol;
  // a node holds a payload exactly when it has an entry in stored_pay.
  // ---------------------------------------------------------------------------
  int unsigned          link_of [int unsigned];
  logic [PAYLOAD_W-1:0] stored_pay [int unsigned];
  int unsigned          free_node = 1;
  int unsigned          walk_node = 0;
  bit                   walk_failed = 1'b0;

  twl_out_t word_answers_q [$];   // answers still owed by the block, oldest first

  int unsigned in_gap_max    = 0;
  int unsigned out_stall_max = 0;
  int unsigned items_sent    = 0;
  int unsigned n_ok          = 0;
  int unsigned n_miss        = 0;
  int unsigned n_full        = 0;
  int unsigned fail_count    = 0;
  int unsigned idle_cycles   = 0;

  // Word under construction, plus a dictionary of inserted words for re-queries.
  logic [7:0]  wbuf [WORD_MAX];
  logic [7:0]  dict_chr [DICT_MAX][WORD_MAX];
  int unsigned dict_len [DICT_MAX];
  int unsigned dict_size = 0;

  // a-z -> 0..25, 0-9 -> 26..35, underscore -> 36, every other byte -> 0
  function automatic int unsigned char_symbol(input logic [7:0] c);
    if (c >= CH_LC_A && c <= CH_LC_Z) return int'(c - CH_LC_A);
    if (c >= CH_D0 && c <= CH_D9) return 26 + int'(c - CH_D0);
    if (c == CH_US) return 36;
    return 0;
  endfunction

  function automatic logic [7:0] sym_char(input int unsigned s);
    if (s < 26) return 8'(CH_LC_A + s);
    if (s < 36) return 8'(CH_D0 + (s - 26));
    return CH_US;
  endfunction

  // Advance the model by one character; returns 1 when the word ends.
  function automatic bit trie_step(input twl_in_t it, output twl_out_t res);
    int unsigned slot;
    res = '0;
    if (!walk_failed) begin
      slot = walk_node * ALPHABET_SIZE + char_symbol(it.char_code);
      if (link_of.exists(slot)) begin
        walk_node = link_of[slot];
      end else if (it.opcode != OP_INSERT || free_node >= NODE_COUNT) begin
        walk_failed = 1'b1;
      end else begin
        link_of[slot] = free_node;
        walk_node = free_node;
        free_node++;
      end
    end
    if (!it.last_char) return 1'b0;

    if (walk_failed) begin
      // the opcode of the last character decides which failure is reported
      if (it.opcode == OP_INSERT) res.status = ST_FULL;
      else res.status = ST_MISS;
    end else if (it.opcode == OP_INSERT) begin
      stored_pay[walk_node] = it.payload_index;
      res.status = ST_OK;
      res.result_index = it.payload_index;
    end else if (stored_pay.exists(walk_node)) begin
      res.status = ST_OK;
      res.result_index = stored_pay[walk_node];
    end else begin
      res.status = ST_MISS;   // prefix only, or never stored
    end
    walk_node = 0;
    walk_failed = 1'b0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Valid is held until the handshake; with a zero gap the next
  // item is driven in the same step as the previous acceptance.
  // ---------------------------------------------------------------------------
  task automatic send_char(input logic op, input logic [7:0] ch, input logic last,
                           input logic [PAYLOAD_W-1:0] pay);
    twl_in_t     it;
    twl_out_t    res;
    int unsigned gap;
    it.opcode        = op;
    it.char_code     = ch;
    it.last_char     = last;
    it.payload_index = pay;
    if (trie_step(it, res)) begin
      word_answers_q.push_back(res);
      case (res.status)
        ST_OK:   n_ok++;
        ST_MISS: n_miss++;
        default: n_full++;
      endcase
    end
    gap = $urandom_range(in_gap_max, 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_word(input int unsigned len, input word_kind_e kind,
                           input logic [PAYLOAD_W-1:0] pay);
    int unsigned k;
    logic        op;
    for (k = 0; k < len; k++) begin
      case (kind)
        WORD_QUERY:  op = OP_QUERY;
        WORD_INSERT: op = OP_INSERT;
        default:     op = logic'($urandom_range(1, 0));
      endcase
      // payload on inner characters is noise the block must ignore
      send_char(op, wbuf[k], k == len - 1, (k == len - 1) ? pay : PAYLOAD_W'($urandom));
    end
  endtask

  task automatic send_text(input logic op, input string s, input logic [PAYLOAD_W-1:0] pay);
    int unsigned k;
    for (k = 0; k < s.len(); k++)
      send_char(op, s[k], k == s.len() - 1, (k == s.len() - 1) ? pay : PAYLOAD_W'($urandom));
  endtask

  // Mostly a-d so that words share prefixes; some of the full alphabet and raw bytes.
  function automatic logic [7:0] rand_char();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 60) return 8'(CH_LC_A + $urandom_range(3, 0));
    if (r < 85) return sym_char($urandom_range(ALPHABET_SIZE - 1, 0));
    return 8'($urandom_range(255, 0));
  endfunction

  function automatic void rand_word(input int unsigned len);
    int unsigned k;
    for (k = 0; k < len; k++) wbuf[k] = rand_char();
  endfunction

  function automatic int unsigned load_dict(input int unsigned idx);
    int unsigned k;
    for (k = 0; k < dict_len[idx]; k++) wbuf[k] = dict_chr[idx][k];
    return dict_len[idx];
  endfunction

  function automatic void remember_word(input int unsigned len);
    int unsigned idx;
    int unsigned k;
    if (dict_size < DICT_MAX) begin
      idx = dict_size;
      dict_size++;
    end else begin
      idx = $urandom_range(DICT_MAX - 1, 0);
    end
    for (k = 0; k < len; k++) dict_chr[idx][k] = wbuf[k];
    dict_len[idx] = len;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random stall before each result, ready held until it is taken.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(out_stall_max, 0);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Compare each accepted answer against the oldest one owed.
  twl_out_t owed;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (word_answers_q.size() == 0) begin
        $display("%0t: unexpected result: status %0d index %0d", $time,
                 out_item.status, out_item.result_index);
        fail_count++;
      end else begin
        owed = word_answers_q.pop_front();
        if (out_item.status !== owed.status) begin
          $display("%0t: status mismatch: expected %0d, got %0d", $time,
                   owed.status, out_item.status);
        end
        if (out_item.result_index !== owed.result_index) begin
          $display("%0t: result_index mismatch: expected %0d, got %0d", $time,
                   owed.result_index, out_item.result_index);
        end
        if (out_item !== owed) fail_count++;
      end
    end
  end

  // Watchdog: too long without any handshake means the block has hung.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d answers still owed", $time,
               idle_cycles, word_answers_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Short hand-built words: empty-trie miss, payload extremes, prefix-only miss,
  // overwrite, end-of-alphabet symbols, bytes that alias to 'a', mixed opcodes.
  task automatic test_directed();
    in_gap_max    = 3;
    out_stall_max = 3;
    send_text(OP_QUERY,  "a",   '0);
    send_text(OP_INSERT, "cat", 17'h1FFFF);
    send_text(OP_QUERY,  "cat", 17'h0);
    send_text(OP_QUERY,  "ca",  17'h1FFFF);   // node exists, nothing stored
    send_text(OP_INSERT, "cat", 17'h0);       // overwrite
    send_text(OP_QUERY,  "cat", 17'h15555);
    send_text(OP_INSERT, "z9_", 17'h15555);
    // 0xFF and 0x00 both fall back to symbol 0, so "aA" must find this word
    send_char(OP_INSERT, 8'hFF, 1'b0, 17'h1FFFF);
    send_char(OP_INSERT, 8'h00, 1'b1, 17'h0AAAA);
    send_text(OP_QUERY,  "aA",  17'h0);
    // insert then query in one word: the query side misses
    send_char(OP_INSERT, "q", 1'b0, 17'h0);
    send_char(OP_QUERY,  "x", 1'b1, 17'h1FFFF);
    // failed query then insert on the last char: reported as pool full
    send_char(OP_QUERY,  "m", 1'b0, 17'h0);
    send_char(OP_INSERT, "n", 1'b1, 17'h1FFFF);
  endtask

  // Random word traffic over a small alphabet so that paths are shared; idling
  // patterns rotate at word starts after each 150 items, with stretches of no idling.
  task automatic test_random_words();
    int unsigned pick;
    int unsigned len;
    int unsigned idx;
    int unsigned mode = 0;
    int unsigned next_switch;
    logic [PAYLOAD_W-1:0] pay;
    next_switch = items_sent;
    while (items_sent < RAND_ITEMS) begin
      if (items_sent >= next_switch) begin
        mode = (mode + 1) % 4;
        in_gap_max    = (mode[0]) ? 6 : 0;
        out_stall_max = (mode[1]) ? 6 : 0;
        next_switch   = items_sent + 150;
      end
      pick = $urandom_range(99, 0);
      pay  = PAYLOAD_W'($urandom);
      if (pick < 5) pay = (pick[0]) ? '1 : '0;
      if (dict_size == 0) pick = 0;
      idx = (dict_size == 0) ? 0 : $urandom_range(dict_size - 1, 0);
      if (pick < 30) begin
        len = $urandom_range(WORD_MAX, 1);
        rand_word(len);
        send_word(len, WORD_INSERT, pay);
        remember_word(len);
      end else if (pick < 55) begin
        send_word(load_dict(idx), WORD_QUERY, pay);
      end else if (pick < 65) begin
        len = load_dict(idx);
        if (len > 1) len = $urandom_range(len - 1, 1);
        send_word(len, WORD_QUERY, pay);
      end else if (pick < 75) begin
        send_word(load_dict(idx), WORD_INSERT, pay);
      end else if (pick < 90) begin
        len = $urandom_range(WORD_MAX, 1);
        rand_word(len);
        send_word(len, WORD_QUERY, pay);
      end else begin
        len = (pick[0]) ? load_dict(idx) : $urandom_range(WORD_MAX, 1);
        if (!pick[0]) rand_word(len);
        send_word(len, WORD_MIXED, pay);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    out_ready <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_words();
    in_valid <= 1'b0;

    // all answers in, then a few quiet cycles to catch stray results
    while (word_answers_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d characters forming %0d words: %0d hits or stores, %0d misses, %0d full.",
             items_sent, n_ok + n_miss + n_full, n_ok, n_miss, n_full);
    $display("Trie ended with %0d of %0d nodes in use, %0d mismatching answers.",
             free_node, NODE_COUNT, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
